@@ src/cbls_pkg.sv @@
`timescale 1ns / 1ps

package cbls_pkg;

    localparam int NUM_CHAN = 4;
    localparam int CHAN_W = 8;
    localparam int LEN_W = 2 * CHAN_W;

    localparam logic [1:0] CH_ZERO  = 2'd0;
    localparam logic [1:0] CH_ONE   = 2'd1;
    localparam logic [1:0] CH_TWO   = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [LEN_W-1:0] len_t;

    // per-cycle control shared by all lanes
    typedef struct packed {
        logic accept;
        logic first;
        logic load_s1;
        logic load_s2;
    } lane_ctl_t;

endpackage

@@ src/color_box_longest_side.sv @@
`timescale 1ns / 1ps
// one pixel accepted per cycle while pixel_stall is low; each channel lane updates its corners on every accepted pixel
// result appears on box_valid after the last pixel of a run is accepted, passing through these registered steps:
// corners captured at the accepting edge, lane multiply, then merge compare into the output
// a new run may start in the cycle right after a last pixel
// reset clears the open-run flag and the stage valid flags; corner registers are not reset

module color_box_longest_side
    import cbls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  chan_zero,
    input  logic [7:0]  chan_one,
    input  logic [7:0]  chan_two,
    input  logic [7:0]  chan_alpha,
    input  logic        last_pixel,
    output logic        box_valid,
    input  logic        box_stall,
    output logic [7:0]  min_zero,
    output logic [7:0]  min_one,
    output logic [7:0]  min_two,
    output logic [7:0]  min_alpha,
    output logic [7:0]  max_zero,
    output logic [7:0]  max_one,
    output logic [7:0]  max_two,
    output logic [7:0]  max_alpha,
    output logic [1:0]  longest_index,
    output logic [15:0] longest_length
);

    logic in_run_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic accept;
    logic load3;
    lane_ctl_t ctl;

    chan_t pix      [NUM_CHAN];
    chan_t s1_max   [NUM_CHAN];
    chan_t s2_min   [NUM_CHAN];
    chan_t s2_max   [NUM_CHAN];
    len_t  s2_len   [NUM_CHAN];
    chan_t box_min  [NUM_CHAN];
    chan_t box_max  [NUM_CHAN];

    assign rdy3 = !v3_reg || !box_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pixel_stall = !rdy1;
    assign accept = pixel_valid && rdy1;
    assign load3 = v2_reg && rdy3;

    assign ctl.accept = accept;
    assign ctl.first = !in_run_reg;
    assign ctl.load_s1 = accept && last_pixel;
    assign ctl.load_s2 = v1_reg && rdy2;

    assign pix[CH_ZERO] = chan_zero;
    assign pix[CH_ONE] = chan_one;
    assign pix[CH_TWO] = chan_two;
    assign pix[CH_ALPHA] = chan_alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_run_reg <= !last_pixel;
            if (ctl.load_s1)
                v1_reg <= 1'b1;
            else if (ctl.load_s2)
                v1_reg <= 1'b0;
            if (ctl.load_s2)
                v2_reg <= 1'b1;
            else if (load3)
                v2_reg <= 1'b0;
            if (load3)
                v3_reg <= 1'b1;
            else if (!box_stall)
                v3_reg <= 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_lane
        // alpha side uses full scale, color sides use the run's max alpha
        chan_t weight;
        assign weight = (g == int'(CH_ALPHA)) ? FULL_SCALE : s1_max[CH_ALPHA];

        cbls_lane u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .pix    (pix[g]),
            .weight (weight),
            .s1_max (s1_max[g]),
            .s2_min (s2_min[g]),
            .s2_max (s2_max[g]),
            .s2_len (s2_len[g])
        );
    end

    cbls_merge u_merge (
        .clk         (clk),
        .load        (load3),
        .lane_min    (s2_min),
        .lane_max    (s2_max),
        .lane_len    (s2_len),
        .box_min     (box_min),
        .box_max     (box_max),
        .best_index  (longest_index),
        .best_length (longest_length)
    );

    assign box_valid = v3_reg;
    assign min_zero = box_min[CH_ZERO];
    assign min_one = box_min[CH_ONE];
    assign min_two = box_min[CH_TWO];
    assign min_alpha = box_min[CH_ALPHA];
    assign max_zero = box_max[CH_ZERO];
    assign max_one = box_max[CH_ONE];
    assign max_two = box_max[CH_TWO];
    assign max_alpha = box_max[CH_ALPHA];

endmodule

@@ src/cbls_lane.sv @@
`timescale 1ns / 1ps

module cbls_lane
    import cbls_pkg::*;
(
    input  logic      clk,
    input  lane_ctl_t ctl,
    input  chan_t     pix,
    input  chan_t     weight,
    output chan_t     s1_max,
    output chan_t     s2_min,
    output chan_t     s2_max,
    output len_t      s2_len
);

    chan_t run_min_reg;
    chan_t run_max_reg;
    chan_t run_min_next;
    chan_t run_max_next;
    chan_t s1_min_reg;
    chan_t s1_max_reg;
    chan_t s2_min_reg;
    chan_t s2_max_reg;
    len_t  s2_len_reg;
    chan_t side;

    always_comb
    begin
        if (ctl.first)
        begin
            run_min_next = pix;
            run_max_next = pix;
        end
        else
        begin
            run_min_next = (pix < run_min_reg) ? pix : run_min_reg;
            run_max_next = (pix > run_max_reg) ? pix : run_max_reg;
        end
    end

    assign side = s1_max_reg - s1_min_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
        end
        // corners of the closing run, captured with the last pixel
        if (ctl.load_s1)
        begin
            s1_min_reg <= run_min_next;
            s1_max_reg <= run_max_next;
        end
        if (ctl.load_s2)
        begin
            s2_min_reg <= s1_min_reg;
            s2_max_reg <= s1_max_reg;
            s2_len_reg <= {{CHAN_W{1'b0}}, side} * {{CHAN_W{1'b0}}, weight};
        end
    end

    assign s1_max = s1_max_reg;
    assign s2_min = s2_min_reg;
    assign s2_max = s2_max_reg;
    assign s2_len = s2_len_reg;

endmodule

@@ src/cbls_merge.sv @@
`timescale 1ns / 1ps

module cbls_merge
    import cbls_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  chan_t      lane_min [NUM_CHAN],
    input  chan_t      lane_max [NUM_CHAN],
    input  len_t       lane_len [NUM_CHAN],
    output chan_t      box_min  [NUM_CHAN],
    output chan_t      box_max  [NUM_CHAN],
    output logic [1:0] best_index,
    output len_t       best_length
);

    localparam logic [1:0] ORDER [NUM_CHAN] = '{CH_ALPHA, CH_ONE, CH_TWO, CH_ZERO};

    chan_t      min_reg [NUM_CHAN];
    chan_t      max_reg [NUM_CHAN];
    logic [1:0] index_reg;
    len_t       length_reg;
    logic [1:0] index_next;
    len_t       length_next;

    // strict greater-than keeps the earlier channel on a tie
    always_comb
    begin
        index_next = CH_ZERO;
        length_next = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            if (lane_len[ORDER[k]] > length_next)
            begin
                length_next = lane_len[ORDER[k]];
                index_next = ORDER[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            min_reg <= lane_min;
            max_reg <= lane_max;
            index_reg <= index_next;
            length_reg <= length_next;
        end
    end

    assign box_min = min_reg;
    assign box_max = max_reg;
    assign best_index = index_reg;
    assign best_length = length_reg;

endmodule

@@ src/cbls_checker.sv @@
`timescale 1ns / 1ps

module cbls_checker
    import cbls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    input  logic        pixel_stall,
    input  logic [7:0]  chan_zero,
    input  logic [7:0]  chan_one,
    input  logic [7:0]  chan_two,
    input  logic [7:0]  chan_alpha,
    input  logic        last_pixel,
    input  logic        box_valid,
    input  logic        box_stall,
    input  logic [7:0]  min_zero,
    input  logic [7:0]  min_one,
    input  logic [7:0]  min_two,
    input  logic [7:0]  min_alpha,
    input  logic [7:0]  max_zero,
    input  logic [7:0]  max_one,
    input  logic [7:0]  max_two,
    input  logic [7:0]  max_alpha,
    input  logic [1:0]  longest_index,
    input  logic [15:0] longest_length
);

    // a stalled transfer stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_stall |=> box_valid)
        else $error("box_valid dropped while stalled");

    a_hold_len: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_stall |=> $stable(longest_length) && $stable(longest_index))
        else $error("result changed while stalled");

    a_corners: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> min_zero <= max_zero && min_one <= max_one &&
                      min_two <= max_two && min_alpha <= max_alpha)
        else $error("box corner inverted");

    a_alpha_len: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && longest_index == CH_ALPHA |->
            longest_length == (16'(max_alpha) - 16'(min_alpha)) * 16'(FULL_SCALE))
        else $error("alpha side length mismatch");

    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && min_zero == max_zero && min_one == max_one &&
        min_two == max_two && min_alpha == max_alpha |->
            longest_length == 16'd0 && longest_index == CH_ZERO)
        else $error("flat box gave a nonzero side");

endmodule

bind color_box_longest_side cbls_checker u_cbls_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import cbls_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PIXELS = 600;

    typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN } stall_mode_e;
    typedef enum int { MIX_FULL, MIX_NARROW, MIX_EXTREME, MIX_OPAQUE } pixel_mix_e;

    typedef struct packed {
        chan_t [NUM_CHAN-1:0] lo;
        chan_t [NUM_CHAN-1:0] hi;
        logic [1:0]           idx;
        len_t                 len;
    } box_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    logic [7:0]  chan_zero = '0;
    logic [7:0]  chan_one = '0;
    logic [7:0]  chan_two = '0;
    logic [7:0]  chan_alpha = '0;
    logic        last_pixel = 1'b0;
    logic        box_valid;
    logic        box_stall = 1'b0;
    logic [7:0]  min_zero;
    logic [7:0]  min_one;
    logic [7:0]  min_two;
    logic [7:0]  min_alpha;
    logic [7:0]  max_zero;
    logic [7:0]  max_one;
    logic [7:0]  max_two;
    logic [7:0]  max_alpha;
    logic [1:0]  longest_index;
    logic [15:0] longest_length;

    color_box_longest_side u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .chan_zero      (chan_zero),
        .chan_one       (chan_one),
        .chan_two       (chan_two),
        .chan_alpha     (chan_alpha),
        .last_pixel     (last_pixel),
        .box_valid      (box_valid),
        .box_stall      (box_stall),
        .min_zero       (min_zero),
        .min_one        (min_one),
        .min_two        (min_two),
        .min_alpha      (min_alpha),
        .max_zero       (max_zero),
        .max_one        (max_one),
        .max_two        (max_two),
        .max_alpha      (max_alpha),
        .longest_index  (longest_index),
        .longest_length (longest_length)
    );

    always #5 clk = ~clk;

    // predictor state: running corners of the open run
    chan_t box_lo [NUM_CHAN];
    chan_t box_hi [NUM_CHAN];
    logic  run_open = 1'b0;
    box_t  pending_boxes [$];

    int fail_count = 0;
    int pixels_seen = 0;
    int runs_closed = 0;
    int boxes_checked = 0;
    int input_held_cycles = 0;
    int idle_cycles = 0;

    // sender and receiver pacing
    stall_mode_e stall_mode = STALL_NONE;
    bit          gaps_on = 1'b0;
    int          burst_left = 0;
    int          hold_tag = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_phase = 0;

    task automatic widen_box();
        chan_t      px [NUM_CHAN];
        box_t       b;
        int         best_len;
        int         side_len;
        int         wgt;
        logic [1:0] ch;
        px[CH_ZERO]  = chan_zero;
        px[CH_ONE]   = chan_one;
        px[CH_TWO]   = chan_two;
        px[CH_ALPHA] = chan_alpha;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (!run_open)
            begin
                box_lo[c] = px[c];
                box_hi[c] = px[c];
            end
            else
            begin
                if (px[c] < box_lo[c])
                    box_lo[c] = px[c];
                if (px[c] > box_hi[c])
                    box_hi[c] = px[c];
            end
        end
        pixels_seen++;
        if (!last_pixel)
            run_open = 1'b1;
        else
        begin
            run_open = 1'b0;
            best_len = 0;
            b.idx = CH_ZERO;
            // alpha first, then one, two, zero; only a strictly longer side takes over
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                case (k)
                    0: ch = CH_ALPHA;
                    1: ch = CH_ONE;
                    2: ch = CH_TWO;
                    default: ch = CH_ZERO;
                endcase
                wgt = (ch == CH_ALPHA) ? int'(FULL_SCALE) : int'(box_hi[CH_ALPHA]);
                side_len = (int'(box_hi[ch]) - int'(box_lo[ch])) * wgt;
                if (side_len > best_len)
                begin
                    best_len = side_len;
                    b.idx = ch;
                end
            end
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                b.lo[c] = box_lo[c];
                b.hi[c] = box_hi[c];
            end
            b.len = len_t'(best_len);
            pending_boxes.push_back(b);
            runs_closed++;
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_box();
        box_t want;
        if (pending_boxes.size() == 0)
        begin
            $error("box transfer with nothing expected");
            fail_count++;
        end
        else
        begin
            want = pending_boxes.pop_front();
            check_field("min_zero", want.lo[CH_ZERO], min_zero);
            check_field("min_one", want.lo[CH_ONE], min_one);
            check_field("min_two", want.lo[CH_TWO], min_two);
            check_field("min_alpha", want.lo[CH_ALPHA], min_alpha);
            check_field("max_zero", want.hi[CH_ZERO], max_zero);
            check_field("max_one", want.hi[CH_ONE], max_one);
            check_field("max_two", want.hi[CH_TWO], max_two);
            check_field("max_alpha", want.hi[CH_ALPHA], max_alpha);
            check_field("longest_index", want.idx, longest_index);
            check_field("longest_length", want.len, longest_length);
            boxes_checked++;
        end
    endtask

    // monitor: check results, feed the predictor, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (box_valid && !box_stall)
                compare_box();
            if (pixel_valid && !pixel_stall)
                widen_box();
            if (pixel_valid && pixel_stall)
                input_held_cycles++;
            if ((box_valid && !box_stall) || (pixel_valid && !pixel_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (hold_seen != hold_tag)
        begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            box_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            box_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:  box_stall <= 1'b0;
                STALL_LIGHT: box_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: box_stall <= ($urandom_range(0, 3) != 0);
                default:     box_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    task automatic send_pixel(input chan_t c0, input chan_t c1, input chan_t c2,
                              input chan_t c3, input logic last);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 8)) @(negedge clk) pixel_valid <= 1'b0;
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        chan_zero   <= c0;
        chan_one    <= c1;
        chan_two    <= c2;
        chan_alpha  <= c3;
        last_pixel  <= last;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk) pixel_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_run(input int len, input pixel_mix_e mix);
        chan_t base [NUM_CHAN];
        chan_t v [NUM_CHAN];
        for (int c = 0; c < NUM_CHAN; c++)
            base[c] = chan_t'($urandom);
        for (int i = 0; i < len; i++)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                case (mix)
                    MIX_FULL:    v[c] = chan_t'($urandom);
                    MIX_NARROW:  v[c] = base[c] + chan_t'($urandom_range(0, 3));
                    MIX_EXTREME: v[c] = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                    default:     v[c] = (c == CH_ALPHA) ? 8'd255 : chan_t'($urandom);
                endcase
            end
            send_pixel(v[CH_ZERO], v[CH_ONE], v[CH_TWO], v[CH_ALPHA], i == len - 1);
        end
    endtask

    task automatic test_single_pixel();
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'hA5, 8'h5A, 8'h0F, 8'hF0, 1'b1);
        drain();
    endtask

    task automatic test_flat_box();
        stall_mode = STALL_LIGHT;
        send_pixel(8'd17, 8'd200, 8'd99, 8'd255, 1'b0);
        send_pixel(8'd17, 8'd200, 8'd99, 8'd255, 1'b0);
        send_pixel(8'd17, 8'd200, 8'd99, 8'd255, 1'b1);
        // zero alpha kills every color side
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        drain();
    endtask

    task automatic test_tie_order();
        stall_mode = STALL_PATTERN;
        // full-scale box: alpha and color sides tie at the top length
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd10, 8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd10, 8'd100, 8'd100, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd5, 8'd0, 8'd200, 1'b0);
        send_pixel(8'd90, 8'd5, 8'd90, 8'd200, 1'b1);
        drain();
    endtask

    task automatic test_channel_winners();
        stall_mode = STALL_HEAVY;
        send_pixel(8'd0, 8'd50, 8'd60, 8'd128, 1'b0);
        send_pixel(8'd250, 8'd70, 8'd80, 8'd130, 1'b1);
        send_pixel(8'd1, 8'd0, 8'd1, 8'd1, 1'b0);
        send_pixel(8'd2, 8'd255, 8'd2, 8'd1, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd1, 8'd200, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        hold_tag = hold_tag + 1;
        // short runs back to back while the receiver holds off
        for (int i = 0; i < 40; i++)
            send_run($urandom_range(1, 2), pixel_mix_e'($urandom_range(0, 3)));
        drain();
    endtask

    task automatic test_random_runs();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 40);
            send_run(len, pixel_mix_e'($urandom_range(0, 3)));
            sent += len;
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);
        test_single_pixel();
        test_flat_box();
        test_tie_order();
        test_channel_winners();
        test_backpressure();
        test_random_runs();
        repeat (10) @(posedge clk);
        if (pending_boxes.size() != 0)
        begin
            $error("%0d boxes never arrived", pending_boxes.size());
            fail_count++;
        end
        $display("run covered %0d pixels in %0d runs, %0d boxes compared",
                 pixels_seen, runs_closed, boxes_checked);
        $display("pixel input held off for %0d cycles under output back-pressure",
                 input_held_cycles);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
